// ===== design/lpip_pkg.sv =====
// Shared types and constants for the lidar point projection unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lpip_pkg;
  localparam int XW   = 18;  // point coordinate width
  localparam int CW   = 32;  // matrix coefficient width
  localparam int PRW  = 50;  // one product
  localparam int PW   = 52;  // row dot product, 24 fraction bits
  localparam int MW   = 54;  // numerator / denominator magnitude
  localparam int DIMW = 13;  // image dimension register width
  localparam int PIXW = 12;  // pixel coordinate width
  localparam int IDXW = 8;   // config register index width
  localparam int DATW = 64;  // config data width

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BEHIND     = 2'd1;
  localparam logic [1:0] ST_ZERO_DEPTH = 2'd2;
  localparam logic [1:0] ST_OUTSIDE    = 2'd3;

  localparam logic [IDXW-1:0] REG_ROW0_01 = 8'd0;
  localparam logic [IDXW-1:0] REG_ROW0_23 = 8'd1;
  localparam logic [IDXW-1:0] REG_ROW1_01 = 8'd2;
  localparam logic [IDXW-1:0] REG_ROW1_23 = 8'd3;
  localparam logic [IDXW-1:0] REG_ROW2_01 = 8'd4;
  localparam logic [IDXW-1:0] REG_ROW2_23 = 8'd5;
  localparam logic [IDXW-1:0] REG_WIDTH   = 8'd6;
  localparam logic [IDXW-1:0] REG_HEIGHT  = 8'd7;

  localparam logic [DIMW-1:0] WIDTH_RST  = 13'd1242;
  localparam logic [DIMW-1:0] HEIGHT_RST = 13'd375;

  // per-item flags that ride alongside the dividers
  typedef struct packed {
    logic behind;
    logic zero;
    logic neg_c;
    logic neg_r;
  } lpip_flags_t;
endpackage

// ===== design/lpip_if.sv =====
// Channel interfaces: point input, pixel result and config write.
// Depends on lpip_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface lpip_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [lpip_pkg::XW-1:0]        point_x;
  logic signed [lpip_pkg::XW-1:0]        point_y;
  logic signed [lpip_pkg::XW-1:0]        point_z;
  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface lpip_out_if;
  logic                          valid;
  logic                          ready;
  logic [lpip_pkg::PIXW-1:0]     pixel_column;
  logic [lpip_pkg::PIXW-1:0]     pixel_row;
  logic [1:0]                    status;
  modport source (output valid, pixel_column, pixel_row, status, input ready);
  modport sink   (input valid, pixel_column, pixel_row, status, output ready);
endinterface

interface lpip_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lpip_pkg::IDXW-1:0]     index;
  logic [lpip_pkg::DATW-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/lidar_point_image_projection_unit.sv =====
// Top level of the lidar point to image pixel projection unit.
// Depends on lpip_pkg, lpip_if (interfaces) and lpip_div.
//
//  channel  | dir | payload                              | transfer when
//  in_ch    | in  | point_x, point_y, point_z (s18 Q9.8) | valid && ready
//  out_ch   | out | pixel_column, pixel_row, status      | valid && ready
//  cfg_ch   | in  | index (8b), data (64b)               | valid && ready
//
// One point per cycle while out_ch is ready; two restoring dividers resolve
// one bit per stage. rst_n is synchronous, active low; it clears stage valids
// and matrix rows and loads the default width and height. Each stage holds
// when full and its successor cannot take; bubbles close up, so points are
// taken while out_ch stalls if a stage is empty. cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none
module lidar_point_image_projection_unit #(
  parameter int MAX_IMAGE_DIM = 4096
) (
  input wire logic clk,
  input wire logic rst_n,
  lpip_in_if.sink    in_ch,
  lpip_out_if.source out_ch,
  lpip_cfg_if.sink   cfg_ch
);
  // largest dimension a 13-bit register can carry after clamping
  localparam int DIM_MAX = (MAX_IMAGE_DIM < 8191) ? MAX_IMAGE_DIM : 8191;
  localparam int QW      = $clog2(DIM_MAX + 1);
  localparam int NS      = QW + 6;  // pipeline stages
  localparam int SD      = 4;       // first divider stage
  localparam int SF      = NS - 1;  // output stage

  localparam int XW   = lpip_pkg::XW;
  localparam int PRW  = lpip_pkg::PRW;
  localparam int PW   = lpip_pkg::PW;
  localparam int MW   = lpip_pkg::MW;
  localparam int DIMW = lpip_pkg::DIMW;
  localparam int PIXW = lpip_pkg::PIXW;

  // ---------------- configuration registers ----------------
  logic [63:0]     row_r [6];
  logic [DIMW-1:0] width_r, height_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) row_r[i] <= '0;
      width_r  <= lpip_pkg::WIDTH_RST;
      height_r <= lpip_pkg::HEIGHT_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        lpip_pkg::REG_ROW0_01: row_r[0] <= cfg_ch.data;
        lpip_pkg::REG_ROW0_23: row_r[1] <= cfg_ch.data;
        lpip_pkg::REG_ROW1_01: row_r[2] <= cfg_ch.data;
        lpip_pkg::REG_ROW1_23: row_r[3] <= cfg_ch.data;
        lpip_pkg::REG_ROW2_01: row_r[4] <= cfg_ch.data;
        lpip_pkg::REG_ROW2_23: row_r[5] <= cfg_ch.data;
        lpip_pkg::REG_WIDTH:   width_r  <= cfg_ch.data[DIMW-1:0];
        lpip_pkg::REG_HEIGHT:  height_r <= cfg_ch.data[DIMW-1:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // ---------------- stage control ----------------
  logic [NS-1:0] v_r;
  logic [NS:0]   en;

  always_comb begin
    en[NS] = out_ch.ready;
    for (int k = NS - 1; k >= 0; k--) en[k] = !v_r[k] || en[k+1];
  end

  assign in_ch.ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_ch.valid;
      for (int k = 1; k < NS; k++) if (en[k]) v_r[k] <= v_r[k-1];
    end
  end

  // ---------------- stage 0: capture point ----------------
  logic signed [XW-1:0] x_r, y_r, z_r;
  always_ff @(posedge clk) begin
    if (en[0]) begin
      x_r <= in_ch.point_x;
      y_r <= in_ch.point_y;
      z_r <= in_ch.point_z;
    end
  end

  // ---------------- stage 1: twelve products ----------------
  // row i: c0*x, c1*y, c2*z, c3*256 (translation)
  logic signed [PRW-1:0] prod_r [3][4];
  logic                  beh1_r;
  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        prod_r[i][0] <= $signed(row_r[2*i][31:0])    * x_r;
        prod_r[i][1] <= $signed(row_r[2*i][63:32])   * y_r;
        prod_r[i][2] <= $signed(row_r[2*i+1][31:0])  * z_r;
        prod_r[i][3] <= PRW'($signed(row_r[2*i+1][63:32])) <<< 8;
      end
      beh1_r <= x_r[XW-1];
    end
  end

  // ---------------- stage 2: row sums ----------------
  logic signed [PW-1:0] p_r [3];
  logic                 beh2_r;
  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int i = 0; i < 3; i++)
        p_r[i] <= PW'(prod_r[i][0]) + PW'(prod_r[i][1])
                + PW'(prod_r[i][2]) + PW'(prod_r[i][3]);
      beh2_r <= beh1_r;
    end
  end

  // ---------------- stage 3: rounded numerators, magnitudes ----------------
  // col = trunc((2*p0 + p2) / (2*p2)), row likewise with p1
  logic signed [MW-1:0] nc, nr, dd;
  assign nc = (MW'(p_r[0]) <<< 1) + MW'(p_r[2]);
  assign nr = (MW'(p_r[1]) <<< 1) + MW'(p_r[2]);
  assign dd = MW'(p_r[2]) <<< 1;

  logic [MW-1:0]       nc_mag_r, nr_mag_r, d_mag_r;
  lpip_pkg::lpip_flags_t fl3_r;
  always_ff @(posedge clk) begin
    if (en[3]) begin
      nc_mag_r     <= nc[MW-1] ? MW'(-nc) : MW'(nc);
      nr_mag_r     <= nr[MW-1] ? MW'(-nr) : MW'(nr);
      d_mag_r      <= dd[MW-1] ? MW'(-dd) : MW'(dd);
      fl3_r.behind <= beh2_r;
      fl3_r.zero   <= (p_r[2] == '0);
      fl3_r.neg_c  <= nc[MW-1] ^ dd[MW-1];
      fl3_r.neg_r  <= nr[MW-1] ^ dd[MW-1];
    end
  end

  // ---------------- stages 4..QW+4: dividers ----------------
  logic [QW-1:0] qc, qr;
  logic          ovc, ovr;

  lpip_div #(.QW(QW)) u_div_col (
    .clk (clk), .en (en[SF-1:SD]), .num (nc_mag_r), .den (d_mag_r),
    .quo (qc), .ovf (ovc)
  );
  lpip_div #(.QW(QW)) u_div_row (
    .clk (clk), .en (en[SF-1:SD]), .num (nr_mag_r), .den (d_mag_r),
    .quo (qr), .ovf (ovr)
  );

  lpip_pkg::lpip_flags_t fl_r [QW+1];
  always_ff @(posedge clk) begin
    if (en[SD]) fl_r[0] <= fl3_r;
    for (int s = 1; s <= QW; s++) if (en[SD+s]) fl_r[s] <= fl_r[s-1];
  end

  // ---------------- output stage: bounds and status ----------------
  logic [DIMW-1:0] w_eff, h_eff;
  logic            col_in, row_in;
  logic [1:0]      st_nxt;
  lpip_pkg::lpip_flags_t fq;

  assign fq    = fl_r[QW];
  assign w_eff = (width_r  > DIMW'(DIM_MAX)) ? DIMW'(DIM_MAX) : width_r;
  assign h_eff = (height_r > DIMW'(DIM_MAX)) ? DIMW'(DIM_MAX) : height_r;
  // a negative quotient is inside only when it truncated to zero
  assign col_in = !ovc && !(fq.neg_c && qc != '0) && (DIMW'(qc) < w_eff);
  assign row_in = !ovr && !(fq.neg_r && qr != '0) && (DIMW'(qr) < h_eff);

  always_comb begin
    if (fq.behind)              st_nxt = lpip_pkg::ST_BEHIND;
    else if (fq.zero)           st_nxt = lpip_pkg::ST_ZERO_DEPTH;
    else if (col_in && row_in)  st_nxt = lpip_pkg::ST_OK;
    else                        st_nxt = lpip_pkg::ST_OUTSIDE;
  end

  logic [PIXW-1:0] col_r, row_q_r;
  logic [1:0]      st_r;
  always_ff @(posedge clk) begin
    if (en[SF]) begin
      st_r    <= st_nxt;
      col_r   <= (st_nxt == lpip_pkg::ST_OK) ? PIXW'(qc) : '0;
      row_q_r <= (st_nxt == lpip_pkg::ST_OK) ? PIXW'(qr) : '0;
    end
  end

  assign out_ch.valid        = v_r[SF];
  assign out_ch.pixel_column = col_r;
  assign out_ch.pixel_row    = row_q_r;
  assign out_ch.status       = st_r;

`ifndef SYNTHESIS
  // pixel fields are zero unless the point projected
  a_pix_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status != lpip_pkg::ST_OK
      |-> out_ch.pixel_column == '0 && out_ch.pixel_row == '0)
    else $error("pixel fields set on a non-projected result");

  // an empty output slot always lets a new point in
  a_take_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input blocked with an empty output stage");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid directly after reset");

  // a projected pixel lies inside the configured image
  a_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == lpip_pkg::ST_OK
      |-> DIMW'(out_ch.pixel_column) < width_r && DIMW'(out_ch.pixel_row) < height_r)
    else $error("projected pixel outside image");
`endif
endmodule
`default_nettype wire

// ===== design/lpip_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with an
// overflow flag for quotients of 2**QW or more. Depends on lpip_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lpip_div #(
  parameter int QW = 13
) (
  input  wire logic                      clk,
  input  wire logic [QW:0]               en,
  input  wire logic [lpip_pkg::MW-1:0]   num,
  input  wire logic [lpip_pkg::MW-1:0]   den,
  output logic      [QW-1:0]             quo,
  output logic                           ovf
);
  localparam int EW = lpip_pkg::MW + QW;

  logic [lpip_pkg::MW-1:0] rem_r [QW+1];
  logic [lpip_pkg::MW-1:0] den_r [QW+1];
  logic [QW-1:0]           q_r   [QW+1];
  logic                    ovf_r [QW+1];

  // stage 0: range check against den * 2**QW
  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem_r[0] <= num;
      den_r[0] <= den;
      q_r[0]   <= '0;
      ovf_r[0] <= EW'(num) >= (EW'(den) << QW);
    end
  end

  for (genvar s = 1; s <= QW; s++) begin : g_stage
    logic [EW-1:0] trial;
    logic          take;
    assign trial = EW'(den_r[s-1]) << (QW - s);
    assign take  = !ovf_r[s-1] && (EW'(rem_r[s-1]) >= trial);
    always_ff @(posedge clk) begin
      if (en[s]) begin
        rem_r[s] <= take ? lpip_pkg::MW'(EW'(rem_r[s-1]) - trial) : rem_r[s-1];
        den_r[s] <= den_r[s-1];
        q_r[s]   <= q_r[s-1] | (take ? (QW'(1) << (QW - s)) : '0);
        ovf_r[s] <= ovf_r[s-1];
      end
    end
  end

  assign quo = q_r[QW];
  assign ovf = ovf_r[QW];
endmodule
`default_nettype wire
